// File: rtl/length_framed_packet_receiver_assert.svh
// Assertion macros for the receiver RTL.
// Depends on nothing; each file that checks its own logic includes this header.
`ifndef LENGTH_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define LENGTH_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LFPR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("length_framed_packet_receiver: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LFPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("length_framed_packet_receiver: next-cycle check failed");

`endif

// File: rtl/lfpr_pkg.sv
// Types and fixed constants of the length-framed packet receiver.
// Used by lfpr_frame_tracker and length_framed_packet_receiver.
`default_nettype none

package lfpr_pkg;

  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 17;
  localparam int ID_W        = 16;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  // Frame bytes that show up in a summary (bytes 0 .. 13).
  localparam int FIELD_BYTES = 14;
  localparam int DATA_BYTES  = 7;
  localparam int DATA_FIRST  = 7;

  localparam logic [COUNT_W-1:0] FRAME_OVERHEAD = 17'd3;
  localparam logic [ID_W-1:0]    LINK_ID        = 16'hFFB0;
  localparam logic [BYTE_W-1:0]  LINK_ON        = 8'h01;
  localparam logic [BYTE_W-1:0]  HEAD_RESET     = 8'hAB;
  localparam logic [BYTE_W-1:0]  END_RESET      = 8'h88;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE  = 2'd1;

  // Frame status codes.
  localparam logic [STATUS_W-1:0] ST_GOOD         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_FRAMING  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CHECKSUM = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED       = 2'd3;

  // Summary of one completed frame.
  typedef struct packed {
    logic [STATUS_W-1:0]                status;
    logic [ID_W-1:0]                    message_id;
    logic [BYTE_W-1:0]                  status_field;
    logic [BYTE_W-1:0]                  control_field;
    logic [DATA_BYTES-1:0][BYTE_W-1:0]  data;
  } frame_summary_t;

endpackage

`default_nettype wire

// File: rtl/length_framed_packet_receiver.sv
// Top level of the length-framed packet receiver: config, link flag, result register.
// Depends on lfpr_pkg, lfpr_frame_tracker and length_framed_packet_receiver_assert.svh.
//
// Takes one received byte per cycle while rx_ready is high. Bytes 1 and 2 give a
// big-endian length and the frame closes after length plus 3 bytes; its summary
// (status, ID, status and control bytes, data bytes 7 to 13, link flag) appears in
// the output register in the cycle after the closing byte. The count, sum and
// compare logic is combinational. While a summary waits unaccepted, bytes that
// cannot close a frame keep flowing; the third byte of a frame and a byte that
// would close one wait until the output register frees.
// No clearing pass after reset: the block is ready in the first cycle.
`default_nettype none
`include "length_framed_packet_receiver_assert.svh"

module length_framed_packet_receiver #(
  parameter int KEPT_BYTES = 14
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Byte input
  input  wire logic                              rx_valid,
  output logic                                   rx_ready,
  input  wire logic [lfpr_pkg::BYTE_W-1:0]       rx_byte,
  // Frame summary output
  output logic                                   frame_valid,
  input  wire logic                              frame_ready,
  output logic [lfpr_pkg::STATUS_W-1:0]          frame_status,
  output logic [lfpr_pkg::ID_W-1:0]              message_id,
  output logic [lfpr_pkg::BYTE_W-1:0]            status_field,
  output logic [lfpr_pkg::BYTE_W-1:0]            control_field,
  output logic [lfpr_pkg::BYTE_W-1:0]            data_byte0,
  output logic [lfpr_pkg::BYTE_W-1:0]            data_byte1,
  output logic [lfpr_pkg::BYTE_W-1:0]            data_byte2,
  output logic [lfpr_pkg::BYTE_W-1:0]            data_byte3,
  output logic [lfpr_pkg::BYTE_W-1:0]            data_byte4,
  output logic [lfpr_pkg::BYTE_W-1:0]            data_byte5,
  output logic [lfpr_pkg::BYTE_W-1:0]            data_byte6,
  output logic                                   link_connected,
  // Configuration writes
  input  wire logic                              cfg_we,
  input  wire logic [lfpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lfpr_pkg::BYTE_W-1:0]       cfg_data
);
  import lfpr_pkg::*;

  logic [BYTE_W-1:0] head_byte;
  logic [BYTE_W-1:0] end_byte;
  logic              connected;
  logic              connected_next;
  logic              rx_accept;
  logic              emit;
  logic              no_emit_next;
  logic              out_free;
  frame_summary_t    summary;
  frame_summary_t    summary_reg;

  lfpr_frame_tracker #(
    .KEPT_BYTES (KEPT_BYTES)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .accept       (rx_accept),
    .rx_byte      (rx_byte),
    .head_byte    (head_byte),
    .end_byte     (end_byte),
    .emit         (emit),
    .no_emit_next (no_emit_next),
    .summary      (summary)
  );

  // Backpressure only for a byte that may close a frame.
  assign out_free  = !frame_valid || frame_ready;
  assign rx_ready  = out_free || no_emit_next;
  assign rx_accept = rx_valid && rx_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= HEAD_RESET;
      end_byte  <= END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAD_BYTE: head_byte <= cfg_data;
        REG_END_BYTE:  end_byte  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Link flag follows good link frames only
  always_comb begin
    connected_next = connected;
    if (emit && (summary.status == ST_GOOD) && (summary.message_id == LINK_ID)) begin
      connected_next = (summary.control_field == LINK_ON);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      connected <= 1'b0;
    end else if (rx_accept) begin
      connected <= connected_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (rx_accept && emit) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept && emit) begin
      summary_reg    <= summary;
      link_connected <= connected_next;
    end
  end

  assign frame_status  = summary_reg.status;
  assign message_id    = summary_reg.message_id;
  assign status_field  = summary_reg.status_field;
  assign control_field = summary_reg.control_field;
  assign data_byte0    = summary_reg.data[0];
  assign data_byte1    = summary_reg.data[1];
  assign data_byte2    = summary_reg.data[2];
  assign data_byte3    = summary_reg.data[3];
  assign data_byte4    = summary_reg.data[4];
  assign data_byte5    = summary_reg.data[5];
  assign data_byte6    = summary_reg.data[6];

  // A closing byte never overwrites a summary that is still waiting.
  `LFPR_ASSERT_NOW(a_no_overwrite, clk, rst, rx_accept && emit, out_free)
  // The link flag moves only when a frame closes.
  `LFPR_ASSERT_NEXT(a_link_hold, clk, rst, !(rx_accept && emit), $stable(connected))
  // A good link frame reports the flag set from its control byte.
  `LFPR_ASSERT_NOW(a_link_report, clk, rst,
    frame_valid && (frame_status == ST_GOOD) && (message_id == LINK_ID),
    link_connected == (control_field == LINK_ON))
  // Reported status is one of the three defined codes.
  `LFPR_ASSERT_NOW(a_status_code, clk, rst, frame_valid, frame_status != ST_UNUSED)

endmodule

`default_nettype wire

// File: rtl/lfpr_frame_tracker.sv
// Per-byte frame tracking: byte count, leading bytes, lagged checksum.
// Depends on lfpr_pkg; instantiated by length_framed_packet_receiver.
`default_nettype none

module lfpr_frame_tracker #(
  parameter int KEPT_BYTES = 14
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire logic [lfpr_pkg::BYTE_W-1:0]     rx_byte,
  input  wire logic [lfpr_pkg::BYTE_W-1:0]     head_byte,
  input  wire logic [lfpr_pkg::BYTE_W-1:0]     end_byte,
  output logic                                 emit,
  output logic                                 no_emit_next,
  output lfpr_pkg::frame_summary_t             summary
);
  import lfpr_pkg::*;

  // Only the bytes a summary can show need storage.
  localparam int STORE = (KEPT_BYTES < FIELD_BYTES) ? KEPT_BYTES : FIELD_BYTES;

  logic [COUNT_W-1:0] byte_count;
  logic [BYTE_W-1:0]  leading_bytes [STORE];
  logic [BYTE_W-1:0]  sum_lagged;
  logic [BYTE_W-1:0]  prev0;
  logic [BYTE_W-1:0]  prev1;

  logic [BYTE_W-1:0]  leading_next [STORE];
  logic [BYTE_W-1:0]  kept_b [FIELD_BYTES];
  logic [BYTE_W-1:0]  sum_next;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] target;
  logic [COUNT_W-1:0] target_now;
  logic               framing_bad;

  // Leading bytes with the current byte written at its position.
  always_comb begin
    for (int i = 0; i < STORE; i++) begin
      leading_next[i] = (byte_count == COUNT_W'(i)) ? rx_byte : leading_bytes[i];
    end
  end

  // Bytes past the stored ones read zero.
  for (genvar j = 0; j < FIELD_BYTES; j++) begin : g_kept
    if (j < STORE) begin : g_store
      assign kept_b[j] = leading_next[j];
    end else begin : g_zero
      assign kept_b[j] = '0;
    end
  end

  // Frame end detection and checksum.
  always_comb begin
    count_inc  = byte_count + COUNT_W'(1);
    target     = {1'b0, leading_next[1], leading_next[2]} + FRAME_OVERHEAD;
    target_now = {1'b0, leading_bytes[1], leading_bytes[2]} + FRAME_OVERHEAD;
    emit       = (count_inc == target);
    sum_next   = (byte_count >= COUNT_W'(2)) ? (sum_lagged + prev1) : sum_lagged;
    // Past byte two the length is settled, so completion is known from state.
    no_emit_next = (byte_count < COUNT_W'(2)) ||
                   ((byte_count > COUNT_W'(2)) && (count_inc != target_now));
    framing_bad = (leading_next[0] != head_byte) || (rx_byte != end_byte);
  end

  // Summary fields; checksum byte is the one before the end byte.
  always_comb begin
    if (framing_bad) begin
      summary.status = ST_BAD_FRAMING;
    end else if (sum_next != prev0) begin
      summary.status = ST_BAD_CHECKSUM;
    end else begin
      summary.status = ST_GOOD;
    end
    summary.message_id    = {kept_b[3], kept_b[4]};
    summary.status_field  = kept_b[5];
    summary.control_field = kept_b[6];
    for (int k = 0; k < DATA_BYTES; k++) begin
      summary.data[k] = kept_b[DATA_FIRST + k];
    end
  end

  // Framing state; cleared at reset and after each completed frame.
  always_ff @(posedge clk) begin
    if (rst || (accept && emit)) begin
      byte_count <= '0;
      sum_lagged <= '0;
      prev0      <= '0;
      prev1      <= '0;
      for (int i = 0; i < STORE; i++) begin
        leading_bytes[i] <= '0;
      end
    end else if (accept) begin
      byte_count <= count_inc;
      sum_lagged <= sum_next;
      prev0      <= rx_byte;
      prev1      <= prev0;
      for (int i = 0; i < STORE; i++) begin
        leading_bytes[i] <= leading_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/length_framed_packet_receiver_test.sv
// Self-checking testbench for length_framed_packet_receiver: directed frames, then random
// framed byte streams under several head/end settings, checked against a local frame parser.
// Depends on lfpr_pkg and the length_framed_packet_receiver RTL.
module length_framed_packet_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lfpr_pkg::*;

  localparam int KEPT_BYTES    = 14;
  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_BYTES   = 340;
  localparam int PHASES        = 5;
  localparam int DIRECTED_ROWS = 4;
  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_HEAD, FLAW_END, FLAW_SUM, FLAW_NOISE} frame_flaw_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_STRETCH} sink_mode_t;

  typedef struct packed {
    frame_summary_t summary;
    logic           link;
  } frame_expect_t;

  // One directed frame; fixed_result rows carry a hand-written status, ID and link flag.
  typedef struct packed {
    logic [3:0]                 n;
    logic [0:8][BYTE_W-1:0]     b;
    logic                       fixed_result;
    logic [STATUS_W-1:0]        st;
    logic [ID_W-1:0]            id;
    logic                       lnk;
  } directed_row_t;

  logic                 clk;
  logic                 rst         = 1'b1;
  logic                 rx_valid    = 1'b0;
  logic                 rx_ready;
  logic [BYTE_W-1:0]    rx_byte     = '0;
  logic                 frame_valid;
  logic                 frame_ready = 1'b0;
  logic [STATUS_W-1:0]  frame_status;
  logic [ID_W-1:0]      message_id;
  logic [BYTE_W-1:0]    status_field;
  logic [BYTE_W-1:0]    control_field;
  logic [BYTE_W-1:0]    data_byte0;
  logic [BYTE_W-1:0]    data_byte1;
  logic [BYTE_W-1:0]    data_byte2;
  logic [BYTE_W-1:0]    data_byte3;
  logic [BYTE_W-1:0]    data_byte4;
  logic [BYTE_W-1:0]    data_byte5;
  logic [BYTE_W-1:0]    data_byte6;
  logic                 link_connected;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [BYTE_W-1:0]    cfg_data    = '0;

  // Parser state and register copies
  logic [COUNT_W-1:0]   rx_count;
  logic [BYTE_W-1:0]    head_kept [KEPT_BYTES];
  logic [BYTE_W-1:0]    running_sum;
  logic [BYTE_W-1:0]    last_two [2];
  logic                 link_flag;
  logic [BYTE_W-1:0]    want_head;
  logic [BYTE_W-1:0]    want_end;

  frame_expect_t        pending_summaries [$];
  int                   mismatch_count = 0;
  int                   frames_checked = 0;
  int                   good_frames = 0;
  int                   framing_errors = 0;
  int                   checksum_errors = 0;
  int                   bytes_sent = 0;
  int                   frames_sent = 0;
  int                   longest_frame = 0;
  int                   burst_left = 0;
  int                   idle_cycles = 0;

  length_framed_packet_receiver #(.KEPT_BYTES(KEPT_BYTES)) dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .frame_valid(frame_valid), .frame_ready(frame_ready),
    .frame_status(frame_status), .message_id(message_id),
    .status_field(status_field), .control_field(control_field),
    .data_byte0(data_byte0), .data_byte1(data_byte1), .data_byte2(data_byte2),
    .data_byte3(data_byte3), .data_byte4(data_byte4), .data_byte5(data_byte5),
    .data_byte6(data_byte6), .link_connected(link_connected),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- frame parser

  function automatic logic [BYTE_W-1:0] kept_at(input int idx);
    return (idx < KEPT_BYTES) ? head_kept[idx] : 8'h00;
  endfunction

  function automatic void clear_frame_state();
    rx_count    = '0;
    running_sum = '0;
    last_two[0] = '0;
    last_two[1] = '0;
    for (int i = 0; i < KEPT_BYTES; i++) head_kept[i] = '0;
  endfunction

  // Takes one byte; returns 1 with the summary when the byte closes a frame.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] value,
                                    output frame_expect_t summary);
    logic [COUNT_W-1:0] target;
    summary = '0;
    if (rx_count < KEPT_BYTES) head_kept[rx_count] = value;
    // the sum trails by two bytes so it never includes the checksum or end byte
    if (rx_count >= 2) running_sum = running_sum + last_two[1];
    last_two[1] = last_two[0];
    last_two[0] = value;
    rx_count = rx_count + 1'b1;
    target = {1'b0, head_kept[1], head_kept[2]} + FRAME_OVERHEAD;
    if (rx_count != target) return 1'b0;

    if (head_kept[0] != want_head || value != want_end) summary.summary.status = ST_BAD_FRAMING;
    else if (running_sum != last_two[1]) summary.summary.status = ST_BAD_CHECKSUM;
    else summary.summary.status = ST_GOOD;
    summary.summary.message_id    = {kept_at(3), kept_at(4)};
    summary.summary.status_field  = kept_at(5);
    summary.summary.control_field = kept_at(6);
    for (int k = 0; k < DATA_BYTES; k++) summary.summary.data[k] = kept_at(DATA_FIRST + k);
    // only a clean link frame moves the flag
    if (summary.summary.status == ST_GOOD && summary.summary.message_id == LINK_ID)
      link_flag = (kept_at(6) == LINK_ON);
    summary.link = link_flag;
    clear_frame_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- sender side

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    frame_expect_t summary;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
    end
    burst_left--;
    rx_valid <= 1'b1;
    rx_byte  <= value;
    do @(posedge clk); while (!rx_ready);
    bytes_sent++;
    if (parse_byte(value, summary)) pending_summaries.push_back(summary);
  endtask

  // Builds a frame of the given length field under the current head/end setting.
  task automatic send_frame(input int unsigned len, input frame_flaw_t flaw);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] value;
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] ctrl;
    sum  = '0;
    id   = ($urandom_range(0, 3) == 0) ? LINK_ID : ID_W'($urandom_range(0, 65535));
    ctrl = ($urandom_range(0, 1) == 0) ? LINK_ON : BYTE_W'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len + 3; i++) begin
      // length bytes win over everything, then noise, then end, checksum, head
      if (i == 1) value = len[15:8];
      else if (i == 2) value = len[7:0];
      else if (flaw == FLAW_NOISE) value = $urandom_range(0, 255);
      else if (i == len + 2)
        value = (flaw == FLAW_END) ? want_end ^ BYTE_W'($urandom_range(1, 255)) : want_end;
      else if (i == len + 1)
        value = (flaw == FLAW_SUM) ? sum + BYTE_W'($urandom_range(1, 255)) : sum;
      else if (i == 0)
        value = (flaw == FLAW_HEAD) ? want_head ^ BYTE_W'($urandom_range(1, 255)) : want_head;
      else if (i == 3) value = id[15:8];
      else if (i == 4) value = id[7:0];
      else if (i == 6) value = ctrl;
      else value = $urandom_range(0, 255);
      if (i <= len) sum = sum + value;
      send_byte(value);
    end
    frames_sent++;
    if (len + 3 > longest_frame) longest_frame = len + 3;
  endtask

  // Holds the sender off until every summary is back, then idles a little.
  task automatic drain_results(input int tail);
    rx_valid <= 1'b0;
    burst_left = 0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HEAD_BYTE: want_head = value;
      REG_END_BYTE:  want_end  = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    directed_row_t     rows [DIRECTED_ROWS];
    frame_expect_t     fixed;
    logic [BYTE_W-1:0] heads [PHASES];
    logic [BYTE_W-1:0] ends [PHASES];
    int                phase_start;
    int unsigned       len;
    int                pick;
    frame_flaw_t       flaw;

    want_head = HEAD_RESET;
    want_end  = END_RESET;
    link_flag = 1'b0;
    clear_frame_state();

    // zero-length frame: end byte is the low length byte, so framing fails
    rows[0] = '{4'd3, {8'hAB, 8'h00, 8'h00, 48'h0}, 1'b1, ST_BAD_FRAMING, 16'h0000, 1'b0};
    // clean link frame with control 0x01
    rows[1] = '{4'd9, {8'hAB, 8'h00, 8'h06, 8'hFF, 8'hB0, 8'h5A, 8'h01, 8'hBB, 8'h88},
                1'b0, ST_GOOD, 16'h0000, 1'b0};
    // link frame with a bad checksum leaves the flag set
    rows[2] = '{4'd9, {8'hAB, 8'h00, 8'h06, 8'hFF, 8'hB0, 8'h00, 8'h00, 8'h61, 8'h88},
                1'b1, ST_BAD_CHECKSUM, 16'hFFB0, 1'b1};
    // one-byte frame with a wrong head; ID low byte lies past the frame
    rows[3] = '{4'd4, {8'h00, 8'h00, 8'h01, 8'hFF, 40'h0}, 1'b1, ST_BAD_FRAMING, 16'hFF00, 1'b1};

    heads[0] = 8'h00;  ends[0] = 8'hFF;
    heads[1] = 8'hFF;  ends[1] = 8'h00;
    heads[2] = $urandom_range(0, 255);  ends[2] = $urandom_range(0, 255);
    heads[3] = $urandom_range(0, 255);  ends[3] = $urandom_range(0, 255);
    heads[4] = HEAD_RESET;  ends[4] = END_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      for (int i = 0; i < rows[r].n; i++) send_byte(rows[r].b[i]);
      frames_sent++;
      if (rows[r].fixed_result) begin
        if (pending_summaries.size() == 0) begin
          report_mismatch($sformatf("directed frame %0d closed no summary", r));
        end else begin
          fixed = pending_summaries.pop_back();
          fixed.summary.status     = rows[r].st;
          fixed.summary.message_id = rows[r].id;
          fixed.link               = rows[r].lnk;
          pending_summaries.push_back(fixed);
        end
      end
    end
    longest_frame = 9;

    // Random frames, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      drain_results(4);
      cfg_write(REG_HEAD_BYTE, heads[p]);
      cfg_write(REG_END_BYTE, ends[p]);
      cfg_write((p % 2 == 0) ? REG_SPARE_2 : REG_SPARE_3, $urandom_range(0, 255));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 29) == 0) drain_results($urandom_range(1, 4));
        pick = $urandom_range(0, 79);
        if (pick == 0) len = $urandom_range(256, 520);
        else if (pick < 10) len = $urandom_range(0, 3);
        else len = $urandom_range(4, 16);
        pick = $urandom_range(0, 9);
        case (pick)
          6: flaw = FLAW_HEAD;
          7: flaw = FLAW_END;
          8: flaw = FLAW_SUM;
          9: flaw = FLAW_NOISE;
          default: flaw = FLAW_NONE;
        endcase
        send_frame(len, flaw);
      end
    end

    drain_results(8);
    $display("ran %0d bytes in %0d frames over %0d head/end settings, longest frame %0d bytes",
             bytes_sent, frames_sent, PHASES + 1, longest_frame);
    $display("checked %0d summaries: %0d good, %0d bad framing, %0d bad checksum",
             frames_checked, good_frames, framing_errors, checksum_errors);
    if (mismatch_count == 0 && pending_summaries.size() == 0) begin
      $display("length_framed_packet_receiver_test: clean");
    end else begin
      $display("length_framed_packet_receiver_test: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("summary %0d %s got %h expected %h",
                                frames_checked, name, got, want));
  endtask

  // Compare each accepted summary with the oldest one predicted
  always @(posedge clk) begin : summary_check
    frame_expect_t want;
    if (!rst && frame_valid && frame_ready) begin
      if (pending_summaries.size() == 0) begin
        report_mismatch($sformatf("summary with no frame closed, id %h", message_id));
      end else begin
        want = pending_summaries.pop_front();
        check_field("frame_status", frame_status, want.summary.status);
        check_field("message_id", message_id, want.summary.message_id);
        check_field("status_field", status_field, want.summary.status_field);
        check_field("control_field", control_field, want.summary.control_field);
        check_field("data_byte0", data_byte0, want.summary.data[0]);
        check_field("data_byte1", data_byte1, want.summary.data[1]);
        check_field("data_byte2", data_byte2, want.summary.data[2]);
        check_field("data_byte3", data_byte3, want.summary.data[3]);
        check_field("data_byte4", data_byte4, want.summary.data[4]);
        check_field("data_byte5", data_byte5, want.summary.data[5]);
        check_field("data_byte6", data_byte6, want.summary.data[6]);
        check_field("link_connected", link_connected, want.link);
        frames_checked++;
        case (want.summary.status)
          ST_GOOD:         good_frames++;
          ST_BAD_FRAMING:  framing_errors++;
          default:         checksum_errors++;
        endcase
      end
    end
  end

  // Summary side back-pressure: a randomly drawn mode that is redrawn when its run ends
  always @(posedge clk) begin : summary_sink
    int         mode_left = 0;
    int         stall_left = 0;
    int         tick = 0;
    sink_mode_t mode = SINK_OPEN;
    tick++;
    if (mode_left == 0) begin
      mode      = sink_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    case (mode)
      SINK_OPEN:    frame_ready <= 1'b1;
      SINK_COIN:    frame_ready <= $urandom_range(0, 1);
      SINK_QUARTER: frame_ready <= (tick % 4 == 0);
      default: begin
        if (stall_left != 0) begin
          stall_left--;
          frame_ready <= 1'b0;
        end else begin
          frame_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Ends the run when no request moves on either side for too long
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ready) || (frame_valid && frame_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
      $display("length_framed_packet_receiver_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lfpr_pkg.sv
rtl/lfpr_frame_tracker.sv
rtl/length_framed_packet_receiver.sv
tb/length_framed_packet_receiver_test.sv
